// ----- hw/rtl/sha1_message_digest_defines.svh -----
// Assertion macros used by the SHA-1 digest top level.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SHA1MD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHA1MD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sha1md_pkg.sv -----
// Shared types, constants and state encodings of the SHA-1 digest block.
// No dependencies; imported by the top level and the compression unit.
package sha1md_pkg;

  localparam int unsigned NUM_HASH  = 5;
  localparam int unsigned BUF_WORDS = 16;
  localparam int unsigned BUF_AW    = $clog2(BUF_WORDS);

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_K1   = 7'd20;
  localparam logic [6:0] ROUND_K2   = 7'd40;
  localparam logic [6:0] ROUND_K3   = 7'd60;
  localparam logic [6:0] ROUND_SCHD = 7'd16;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [2:0] IDX_LAST = 3'd4;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [NUM_HASH-1:0][31:0] hash_t;

  localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_PAD,
    TS_COMP,
    TS_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PREP,
    CS_ROUND,
    CS_DONE
  } cmp_state_e;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

endpackage

// ----- hw/rtl/sha1_message_digest.sv -----
// SHA-1 over a byte stream. An item with tuser low absorbs one byte;
// every 64th byte (message or padding) then holds the input while the
// compression unit runs its 80 rounds, one per cycle, against the 16-word block RAM.
// A finish item (tuser high) pads through the same byte path, one pad byte per cycle
// while not compressing (9 to 72 bytes, with one or two compressions), then offers the
// five digest words, word 0 first; the block takes no input until the fifth word is
// taken and returns to the initial hash state for a new message.
`include "sha1_message_digest_defines.svh"

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast_o    // last_word
);

  top_state_e  state_q, state_d;
  pad_sel_e    pad_sel_q, pad_sel_d;
  logic [60:0] cnt_q;
  logic [60:0] len_q;
  logic        fin_q;
  logic [23:0] word_q;
  logic [2:0]  idx_q;
  hash_t       h_q;

  logic        in_acc, fin_acc, byte_en, blk_start, emit_acc, emit_end;
  logic [7:0]  byte_val;
  logic [5:0]  pos;
  logic [2:0]  len_sel;
  logic [63:0] len_bits;

  logic              ram_we;
  logic [BUF_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  hash_t             work;
  cmp_stat_t         cmp_stat;

  assign pos      = cnt_q[5:0];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_acc  = in_acc && s_axis_tuser_i;
  assign emit_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign emit_end = emit_acc && (idx_q == IDX_LAST);
  assign byte_en  = (in_acc && !s_axis_tuser_i) || (state_q == TS_PAD);
  assign blk_start = byte_en && (pos == POS_LAST);

  // length bytes fill positions 56..63, most significant first
  assign len_bits = {len_q, 3'b000};
  assign len_sel  = ~pos[2:0];

  always_comb begin
    byte_val  = s_axis_tdata_i;
    pad_sel_d = pad_sel_q;
    if (state_q == TS_PAD) begin
      unique case (pad_sel_q)
        PAD_MARK: begin
          byte_val  = PAD_BYTE;
          pad_sel_d = PAD_ZERO;
        end
        PAD_ZERO: begin
          if (pos == POS_LEN) begin
            byte_val  = len_bits[{len_sel, 3'b000} +: 8];
            pad_sel_d = PAD_LEN;
          end else begin
            byte_val = '0;
          end
        end
        PAD_LEN:  byte_val = len_bits[{len_sel, 3'b000} +: 8];
        default:  byte_val = '0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (fin_acc) begin
          state_d = TS_PAD;
        end else if (blk_start) begin
          state_d = TS_COMP;
        end
      end
      TS_PAD:  if (blk_start) state_d = TS_COMP;
      TS_COMP: begin
        if (cmp_stat.done) begin
          if (!fin_q) begin
            state_d = TS_IDLE;
          end else if (pad_sel_q == PAD_LEN) begin
            state_d = TS_EMIT;
          end else begin
            state_d = TS_PAD;
          end
        end
      end
      TS_EMIT: if (emit_end) state_d = TS_IDLE;
      default: state_d = TS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      TS_IDLE: s_axis_tready_o = 1'b1;
      TS_EMIT: m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata_o = {5'b00000, idx_q, h_q[idx_q]};
  assign m_axis_tlast_o = (idx_q == IDX_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TS_IDLE;
      pad_sel_q <= PAD_MARK;
      cnt_q     <= '0;
      fin_q     <= 1'b0;
      idx_q     <= '0;
      h_q       <= H_INIT;
    end else begin
      state_q <= state_d;
      if (byte_en) begin
        pad_sel_q <= pad_sel_d;
        cnt_q     <= cnt_q + 61'd1;
      end
      if (fin_acc) begin
        fin_q     <= 1'b1;
        pad_sel_q <= PAD_MARK;
      end
      if (cmp_stat.done) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          h_q[i] <= h_q[i] + work[i];
        end
      end
      if (emit_acc && !emit_end) begin
        idx_q <= idx_q + 3'd1;
      end
      // back to the initial state for the next message
      if (emit_end) begin
        idx_q <= '0;
        fin_q <= 1'b0;
        cnt_q <= '0;
        h_q   <= H_INIT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en) begin
      word_q <= {word_q[15:0], byte_val};
    end
    if (fin_acc) begin
      len_q <= cnt_q;
    end
  end

  // write a word once its fourth byte arrives
  assign ram_we = byte_en && (pos[1:0] == 2'b11);

  sha1md_ram #(
    .WIDTH (32),
    .DEPTH (BUF_WORDS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos[5:2]),
    .wdata_i ({word_q, byte_val}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sha1md_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blk_start),
    .hash_i  (h_q),
    .rdata_i (ram_rdata),
    .raddr_o (ram_raddr),
    .work_o  (work),
    .stat_o  (cmp_stat)
  );

  `SHA1MD_ASSERT_IMP(a_one_side, s_axis_tready_o, !m_axis_tvalid_o, "input and output both open")
  `SHA1MD_ASSERT_IMP(a_cmp_busy, state_q == TS_COMP, cmp_stat.busy || $past(blk_start) == 1'b0, "compression idle during block wait")
  `SHA1MD_ASSERT_NXT(a_fin_stall, fin_acc, !s_axis_tready_o, "input taken right after finish")
  `SHA1MD_ASSERT_IMP(a_last_idx, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[34:32] == IDX_LAST, "last word with wrong index")

endmodule

// ----- hw/rtl/sha1md_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sha1md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sha1md_compress.sv -----
// SHA-1 compression: 80 rounds, one per cycle, over a block read from the buffer RAM.
// Depends on sha1md_pkg; the buffer RAM lives in the top level.
module sha1md_compress
  import sha1md_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hash_t             hash_i,
  input  logic [31:0]       rdata_i,
  output logic [BUF_AW-1:0] raddr_o,
  output hash_t             work_o,
  output cmp_stat_t         stat_o
);

  cmp_state_e state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [15:0][31:0] win_q;
  logic        round_en, load_en;
  logic [31:0] w_cur, w_mix, f_val, k_val, t_val;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:  if (start_i) state_d = CS_PREP;
      CS_PREP:  state_d = CS_ROUND;
      CS_ROUND: if (rnd_q == ROUND_LAST) state_d = CS_DONE;
      CS_DONE:  state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_en     = 1'b0;
    round_en    = 1'b0;
    raddr_o     = '0;
    stat_o.busy = 1'b1;
    stat_o.done = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        load_en     = start_i;
        stat_o.busy = 1'b0;
      end
      CS_PREP: raddr_o = '0;
      CS_ROUND: begin
        round_en = 1'b1;
        // prefetch the word of the next round
        raddr_o  = rnd_q[BUF_AW-1:0] + BUF_AW'(1);
      end
      CS_DONE: stat_o.done = 1'b1;
      default: stat_o.busy = 1'b0;
    endcase
  end

  assign rnd_d = (state_q == CS_PREP) ? 7'd0 : rnd_q + 7'd1;

  assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_cur = (rnd_q < ROUND_SCHD) ? rdata_i : {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (rnd_q < ROUND_K1) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (rnd_q < ROUND_K2) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (rnd_q < ROUND_K3) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CS_PREP || round_en) begin
        rnd_q <= rnd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      a_q <= hash_i[0];
      b_q <= hash_i[1];
      c_q <= hash_i[2];
      d_q <= hash_i[3];
      e_q <= hash_i[4];
    end else if (round_en) begin
      a_q   <= t_val;
      b_q   <= a_q;
      c_q   <= {b_q[1:0], b_q[31:2]};
      d_q   <= c_q;
      e_q   <= d_q;
      win_q <= {w_cur, win_q[15:1]};
    end
  end

  assign work_o = {e_q, d_q, c_q, b_q, a_q};

endmodule
